@@ rtl/rke_pkg.sv @@
// ----------------------------------------------------------------------------
// rke_pkg
// Shared types, constants and base decode for the rolling k-mer encoder.
// ----------------------------------------------------------------------------
package rke_pkg;

   localparam int KMER_LEN  = 12;
   localparam int RUN_W     = $clog2(KMER_LEN + 1);
   localparam int CHAR_W    = 8;
   localparam int POS_W     = 31;
   localparam int WORD_W    = 32;
   localparam int QPOS_W    = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 96;

   localparam logic [RUN_W-1:0]  RUN_FULL   = RUN_W'(KMER_LEN);
   localparam logic [RUN_W-1:0]  RUN_LAST   = RUN_W'(KMER_LEN - 1);
   localparam logic [QPOS_W-1:0] QPOS_SHIFT = QPOS_W'(KMER_LEN - 1);
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      ST_VALID   = 2'd0,
      ST_INVALID = 2'd1,
      ST_DONE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0]  char_pos;
      logic [CHAR_W-1:0] base_char;
   } req_item_type;

   typedef struct packed {
      logic       is_base;
      logic [1:0] code;
   } base_dec_type;

   function automatic base_dec_type decode_base(input logic [CHAR_W-1:0] ch);
      base_dec_type d;
      d.is_base = 1'b1;
      case (ch) inside
         8'h41, 8'h61: d.code = 2'd0;
         8'h43, 8'h63: d.code = 2'd1;
         8'h47, 8'h67: d.code = 2'd2;
         8'h54, 8'h74: d.code = 2'd3;
         default: begin
            d.is_base = 1'b0;
            d.code    = 2'd0;
         end
      endcase
      return d;
   endfunction

endpackage

@@ rtl/rke_in_stage.sv @@
// ----------------------------------------------------------------------------
// rke_in_stage
// Input register: captures one request and holds it until the update
// stage takes it.
// ----------------------------------------------------------------------------
module rke_in_stage import rke_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign in_ready  = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

@@ rtl/rke_kmer_core.sv @@
// ----------------------------------------------------------------------------
// rke_kmer_core
// Rolling forward and reverse-complement words, valid-base run count and
// the result register.
// ----------------------------------------------------------------------------
module rke_kmer_core import rke_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              direction,
   input  logic              item_valid,
   output logic              item_take,
   input  req_item_type      item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output status_type        rsp_status,
   output logic [WORD_W-1:0] rsp_fwd,
   output logic [WORD_W-1:0] rsp_rc,
   output logic [QPOS_W-1:0] rsp_qpos
);

   logic [WORD_W-1:0] fwd_ff, fwd_in, rc_ff, rc_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [WORD_W-1:0] out_fwd_ff, out_fwd_in, out_rc_ff, out_rc_in;
   logic [QPOS_W-1:0] qpos_ff, qpos_in;

   base_dec_type      dec;
   logic [1:0]        comp;
   logic              emit;
   logic [QPOS_W-1:0] pos_ext;

   assign item_take  = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_fwd    = out_fwd_ff;
   assign rsp_rc     = out_rc_ff;
   assign rsp_qpos   = qpos_ff;

   always_comb begin
      dec     = decode_base(item.base_char);
      comp    = 2'd3 - dec.code;
      pos_ext = {1'b0, item.char_pos};
      fwd_in  = fwd_ff;
      rc_in   = rc_ff;
      run_in  = run_ff;
      emit    = 1'b0;
      status_in  = status_ff;
      out_fwd_in = out_fwd_ff;
      out_rc_in  = out_rc_ff;
      qpos_in    = direction ? pos_ext : (pos_ext - QPOS_SHIFT);
      if (item_take) begin
         if (item.base_char == CHAR_NUL) begin
            fwd_in     = '0;
            rc_in      = '0;
            run_in     = '0;
            emit       = 1'b1;
            status_in  = ST_DONE;
            out_fwd_in = '0;
            out_rc_in  = '0;
            qpos_in    = '0;
         end else if (!dec.is_base) begin
            fwd_in     = '0;
            rc_in      = '0;
            run_in     = '0;
            emit       = (run_ff == RUN_FULL);
            status_in  = ST_INVALID;
            out_fwd_in = '0;
            out_rc_in  = '0;
         end else begin
            if (!direction) begin
               fwd_in = {fwd_ff[WORD_W-3:0], dec.code};
               rc_in  = {comp, rc_ff[WORD_W-1:2]};
            end else begin
               fwd_in = {dec.code, fwd_ff[WORD_W-1:2]};
               rc_in  = {rc_ff[WORD_W-3:0], comp};
            end
            if (run_ff != RUN_FULL) begin
               run_in = run_ff + RUN_W'(1);
            end
            emit       = (run_ff >= RUN_LAST);
            status_in  = ST_VALID;
            out_fwd_in = fwd_in;
            out_rc_in  = rc_in;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= '0;
         rc_ff        <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         rc_ff        <= rc_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && emit) begin
         status_ff  <= status_in;
         out_fwd_ff <= out_fwd_in;
         out_rc_ff  <= out_rc_in;
         qpos_ff    <= qpos_in;
      end
   end

   a_run_bounded: assert property (@(posedge clock) disable iff (reset)
      run_ff <= RUN_FULL)
      else $error("run count above k-mer length");

   a_clear_on_break: assert property (@(posedge clock) disable iff (reset)
      item_take && !dec.is_base |=> run_ff == '0 && fwd_ff == '0 && rc_ff == '0)
      else $error("state not cleared after non-base character");

   a_zero_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != ST_VALID |-> out_fwd_ff == '0 && out_rc_ff == '0)
      else $error("non-valid result carries nonzero words");

   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_DONE |-> qpos_ff == '0)
      else $error("done result carries nonzero position");

   a_valid_full: assert property (@(posedge clock) disable iff (reset)
      item_take && emit && status_in == ST_VALID |=> run_ff == RUN_FULL)
      else $error("valid k-mer emitted before window full");

endmodule

@@ rtl/rolling_kmer_encoder_revcomp_core.sv @@
// ----------------------------------------------------------------------------
// rolling_kmer_encoder_revcomp_core
// Rolling 2-bit k-mer encoder with reverse complement, one character per
// cycle while results are taken.
//
//   channel  dir  handshake            contents
//   req_     in   tvalid/tready        character and its query position
//   rsp_     out  tvalid/tready        k-mer pair, window position, status
//   csr_     in   wr_en                direction
//
// One request per cycle sustained while rsp_tready is high; an accepted request
// passes the input register, then the update and result register, before its result.
// Reset clears the words, the run count, the direction and all valid flags.
// A stalled result holds the result register; the input register still
// takes one more request if it is empty, then req_tready drops.
// ----------------------------------------------------------------------------
module rolling_kmer_encoder_revcomp_core import rke_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,     // direction
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,       // base_char[7:0], char_pos[38:8]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,       // forward_word, revcomp_word, query_pos
   output logic [1:0]            rsp_tuser        // status
);

   logic              direction_ff, direction_in;
   req_item_type      req_item, s1_item;
   logic              s1_valid, s1_take;
   status_type        rsp_status;
   logic [WORD_W-1:0] rsp_fwd, rsp_rc;
   logic [QPOS_W-1:0] rsp_qpos;

   assign req_item.base_char = req_tdata[CHAR_W-1:0];
   assign req_item.char_pos  = req_tdata[CHAR_W+POS_W-1:CHAR_W];

   assign direction_in = csr_wr_en ? csr_wr_data : direction_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
      end
   end

   rke_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_take  (s1_take),
      .out_item  (s1_item)
   );

   rke_kmer_core u_kmer_core (
      .clock      (clock),
      .reset      (reset),
      .direction  (direction_ff),
      .item_valid (s1_valid),
      .item_take  (s1_take),
      .item       (s1_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_fwd    (rsp_fwd),
      .rsp_rc     (rsp_rc),
      .rsp_qpos   (rsp_qpos)
   );

   assign rsp_tdata = {rsp_qpos, rsp_rc, rsp_fwd};
   assign rsp_tuser = rsp_status;

endmodule
